// ----- hw/rtl/hsvg_pkg.sv -----
// Shared widths, codes and types of the HSV gradient to RGB core.
package hsvg_pkg;

   localparam int HUE_W      = 13;
   localparam int SV_W       = 9;
   localparam int POS_W      = 13;
   localparam int CH_W       = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;
   localparam int FRAC_W     = 10;
   localparam int NUM_W      = 18;

   localparam logic [HUE_W-1:0] HUE_FULL   = 13'd5760;
   localparam logic [HUE_W-1:0] HUE_HALF   = 13'd2880;
   localparam logic [SV_W-1:0]  UNIT_SV    = 9'd256;
   localparam logic [POS_W-1:0] UNIT_POS   = 13'd4096;
   localparam logic [FRAC_W-1:0] HUE_SECTOR = 10'd960;
   localparam logic [NUM_W:0]   NUM_FULL   = 19'd245760;

   localparam logic [CSR_IDX_W-1:0] CSR_START_HUE        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_SATURATION = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_VALUE      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_END_HUE          = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_END_SATURATION   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_END_VALUE        = 3'd5;

   localparam logic [2:0] SEC_RY = 3'd0;
   localparam logic [2:0] SEC_YG = 3'd1;
   localparam logic [2:0] SEC_GC = 3'd2;
   localparam logic [2:0] SEC_CB = 3'd3;
   localparam logic [2:0] SEC_BM = 3'd4;
   localparam logic [2:0] SEC_MR = 3'd5;

   typedef struct packed {
      logic [HUE_W-1:0] start_hue;
      logic [SV_W-1:0]  start_saturation;
      logic [SV_W-1:0]  start_value;
      logic [HUE_W-1:0] end_hue;
      logic [SV_W-1:0]  end_saturation;
      logic [SV_W-1:0]  end_value;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      logic [HUE_W-1:0] hue;
      logic [SV_W-1:0]  saturation;
      logic [SV_W-1:0]  value;
   } hsv_type;

endpackage

// ----- hw/rtl/hsv_gradient_to_rgb_core.sv -----
// A transaction accepted at one clock edge shows its color once it has passed the whole pipeline.
// Throughput: one transaction per cycle while busy is low, set by the seven-stage pipeline.
// Reset is synchronous; it empties the pipeline and clears all endpoint registers.
// While reset is high busy is high; otherwise busy stays low and results never wait.
// Top level of the HSV gradient to RGB core.
module hsv_gradient_to_rgb_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [hsvg_pkg::POS_W-1:0]        req_position,
   output logic                              rsp_strobe,
   output logic [hsvg_pkg::CH_W-1:0]         rsp_red,
   output logic [hsvg_pkg::CH_W-1:0]         rsp_green,
   output logic [hsvg_pkg::CH_W-1:0]         rsp_blue,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hsvg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hsvg_pkg::CSR_DATA_W-1:0]   csr_data
);

   hsvg_pkg::cfg_type   cfg;
   hsvg_pkg::hsv_type   hsv;
   logic                in_valid;

   assign busy     = reset;
   assign in_valid = start && !busy;

   hsvg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hsvg_interp u_interp (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .position (req_position),
      .cfg      (cfg),
      .hsv      (hsv)
   );

   hsvg_convert u_convert (
      .clock     (clock),
      .reset     (reset),
      .hsv       (hsv),
      .out_valid (rsp_strobe),
      .red       (rsp_red),
      .green     (rsp_green),
      .blue      (rsp_blue)
   );

endmodule

// ----- hw/rtl/hsvg_csr.sv -----
// Configuration registers holding the two HSV endpoints of the gradient.
module hsvg_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hsvg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hsvg_pkg::CSR_DATA_W-1:0]     csr_data,
   output hsvg_pkg::cfg_type                   cfg
);

   hsvg_pkg::cfg_type             cfg_ff;
   hsvg_pkg::cfg_type             cfg_in;
   logic [hsvg_pkg::HUE_W-1:0]    hue_wr;
   logic [hsvg_pkg::SV_W-1:0]     sv_wr;

   assign csr_ready = 1'b1;

   always_comb begin
      hue_wr = (csr_data >= hsvg_pkg::HUE_FULL) ? csr_data - hsvg_pkg::HUE_FULL : csr_data;
      sv_wr  = (csr_data[hsvg_pkg::SV_W-1:0] > hsvg_pkg::UNIT_SV) ?
               hsvg_pkg::UNIT_SV : csr_data[hsvg_pkg::SV_W-1:0];
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hsvg_pkg::CSR_START_HUE:        cfg_in.start_hue        = hue_wr;
            hsvg_pkg::CSR_START_SATURATION: cfg_in.start_saturation = sv_wr;
            hsvg_pkg::CSR_START_VALUE:      cfg_in.start_value      = sv_wr;
            hsvg_pkg::CSR_END_HUE:          cfg_in.end_hue          = hue_wr;
            hsvg_pkg::CSR_END_SATURATION:   cfg_in.end_saturation   = sv_wr;
            hsvg_pkg::CSR_END_VALUE:        cfg_in.end_value        = sv_wr;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/hsvg_interp.sv -----
// Three-stage interpolation of hue, saturation and value along the gradient.
module hsvg_interp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [hsvg_pkg::POS_W-1:0]      position,
   input  hsvg_pkg::cfg_type               cfg,
   output hsvg_pkg::hsv_type               hsv
);

   logic                                s1_valid_ff, s1_valid_in;
   logic [hsvg_pkg::POS_W-1:0]          s1_pos_ff, s1_pos_in;
   logic signed [hsvg_pkg::HUE_W-1:0]   s1_dh_ff, s1_dh_in;
   logic signed [hsvg_pkg::SV_W:0]      s1_ds_ff, s1_ds_in;
   logic signed [hsvg_pkg::SV_W:0]      s1_dv_ff, s1_dv_in;
   logic signed [hsvg_pkg::HUE_W:0]     dh_raw;
   logic signed [hsvg_pkg::HUE_W:0]     dh_wrap;

   logic                                s2_valid_ff, s2_valid_in;
   logic signed [hsvg_pkg::HUE_W-1:0]   s2_fh_ff, s2_fh_in;
   logic signed [hsvg_pkg::SV_W:0]      s2_fs_ff, s2_fs_in;
   logic signed [hsvg_pkg::SV_W:0]      s2_fv_ff, s2_fv_in;
   logic signed [hsvg_pkg::POS_W:0]     pos_s;
   logic signed [26:0]                  prod_h;
   logic signed [23:0]                  prod_s;
   logic signed [23:0]                  prod_v;

   hsvg_pkg::hsv_type                   hsv_ff, hsv_in;
   logic signed [hsvg_pkg::HUE_W+1:0]   hue_sum;
   logic signed [hsvg_pkg::SV_W+1:0]    sat_sum;
   logic signed [hsvg_pkg::SV_W+1:0]    val_sum;

   always_comb begin
      s1_valid_in = in_valid;
      s1_pos_in   = (position > hsvg_pkg::UNIT_POS) ? hsvg_pkg::UNIT_POS : position;
      dh_raw      = $signed({1'b0, cfg.end_hue}) - $signed({1'b0, cfg.start_hue});
      dh_wrap     = dh_raw;
      if (dh_raw > $signed({1'b0, hsvg_pkg::HUE_HALF})) begin
         dh_wrap = dh_raw - $signed({1'b0, hsvg_pkg::HUE_FULL});
      end else if (dh_raw < -$signed({1'b0, hsvg_pkg::HUE_HALF})) begin
         dh_wrap = dh_raw + $signed({1'b0, hsvg_pkg::HUE_FULL});
      end
      s1_dh_in = dh_wrap[hsvg_pkg::HUE_W-1:0];
      s1_ds_in = $signed({1'b0, cfg.end_saturation}) - $signed({1'b0, cfg.start_saturation});
      s1_dv_in = $signed({1'b0, cfg.end_value}) - $signed({1'b0, cfg.start_value});
   end

   always_comb begin
      pos_s       = $signed({1'b0, s1_pos_ff});
      prod_h      = 27'(s1_dh_ff) * 27'(pos_s);
      prod_s      = 24'(s1_ds_ff) * 24'(pos_s);
      prod_v      = 24'(s1_dv_ff) * 24'(pos_s);
      s2_valid_in = s1_valid_ff;
      s2_fh_in    = prod_h[24:12];
      s2_fs_in    = prod_s[21:12];
      s2_fv_in    = prod_v[21:12];
   end

   always_comb begin
      hue_sum = $signed({2'b00, cfg.start_hue}) +
                $signed({{2{s2_fh_ff[hsvg_pkg::HUE_W-1]}}, s2_fh_ff});
      if (hue_sum < 0) begin
         hue_sum = hue_sum + $signed({2'b00, hsvg_pkg::HUE_FULL});
      end else if (hue_sum >= $signed({2'b00, hsvg_pkg::HUE_FULL})) begin
         hue_sum = hue_sum - $signed({2'b00, hsvg_pkg::HUE_FULL});
      end
      sat_sum = $signed({2'b00, cfg.start_saturation}) +
                $signed({s2_fs_ff[hsvg_pkg::SV_W], s2_fs_ff});
      val_sum = $signed({2'b00, cfg.start_value}) +
                $signed({s2_fv_ff[hsvg_pkg::SV_W], s2_fv_ff});
      hsv_in.valid      = s2_valid_ff;
      hsv_in.hue        = hue_sum[hsvg_pkg::HUE_W-1:0];
      hsv_in.saturation = sat_sum[hsvg_pkg::SV_W-1:0];
      hsv_in.value      = val_sum[hsvg_pkg::SV_W-1:0];
   end

   always_ff @(posedge clock) begin
      s1_pos_ff <= s1_pos_in;
      s1_dh_ff  <= s1_dh_in;
      s1_ds_ff  <= s1_ds_in;
      s1_dv_ff  <= s1_dv_in;
      s2_fh_ff  <= s2_fh_in;
      s2_fs_ff  <= s2_fs_in;
      s2_fv_ff  <= s2_fv_in;
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         hsv_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         hsv_ff      <= hsv_in;
      end
   end

   assign hsv = hsv_ff;

endmodule

// ----- hw/rtl/hsvg_convert.sv -----
// Four-stage six-sector HSV to RGB conversion with registered result.
module hsvg_convert (
   input  logic                         clock,
   input  logic                         reset,
   input  hsvg_pkg::hsv_type            hsv,
   output logic                         out_valid,
   output logic [hsvg_pkg::CH_W-1:0]    red,
   output logic [hsvg_pkg::CH_W-1:0]    green,
   output logic [hsvg_pkg::CH_W-1:0]    blue
);

   logic                              s4_valid_ff, s4_valid_in;
   logic [2:0]                        s4_sector_ff, s4_sector_in;
   logic [hsvg_pkg::FRAC_W-1:0]       s4_frac_ff, s4_frac_in;
   logic [hsvg_pkg::SV_W-1:0]         s4_sat_ff, s4_sat_in;
   logic [hsvg_pkg::SV_W-1:0]         s4_val_ff, s4_val_in;
   logic [hsvg_pkg::HUE_W-1:0]        frac_wide;

   logic                              s5_valid_ff, s5_valid_in;
   logic [2:0]                        s5_sector_ff, s5_sector_in;
   logic                              s5_grey_ff, s5_grey_in;
   logic [hsvg_pkg::SV_W-1:0]         s5_val_ff, s5_val_in;
   logic [hsvg_pkg::NUM_W-1:0]        s5_numq_ff, s5_numq_in;
   logic [hsvg_pkg::NUM_W-1:0]        s5_numt_ff, s5_numt_in;
   logic [16:0]                       s5_pp_ff, s5_pp_in;
   logic [hsvg_pkg::NUM_W:0]          sf;
   logic [hsvg_pkg::NUM_W:0]          st;
   logic [hsvg_pkg::NUM_W:0]          numq_wide;
   logic [hsvg_pkg::NUM_W:0]          numt_wide;
   logic [hsvg_pkg::FRAC_W-1:0]       frac_rest;
   logic [hsvg_pkg::SV_W-1:0]         sat_rest;

   logic                              s6_valid_ff, s6_valid_in;
   logic [2:0]                        s6_sector_ff, s6_sector_in;
   logic                              s6_grey_ff, s6_grey_in;
   logic [26:0]                       s6_mq_ff, s6_mq_in;
   logic [26:0]                       s6_mt_ff, s6_mt_in;
   logic [24:0]                       s6_mp_ff, s6_mp_in;
   logic [hsvg_pkg::CH_W-1:0]         s6_vc_ff, s6_vc_in;
   logic [16:0]                       v255;

   logic                              out_valid_ff;
   logic [hsvg_pkg::CH_W-1:0]         red_ff, red_in;
   logic [hsvg_pkg::CH_W-1:0]         green_ff, green_in;
   logic [hsvg_pkg::CH_W-1:0]         blue_ff, blue_in;
   logic [30:0]                       q17;
   logic [30:0]                       t17;
   logic [hsvg_pkg::CH_W-1:0]         qc;
   logic [hsvg_pkg::CH_W-1:0]         tc;
   logic [hsvg_pkg::CH_W-1:0]         pc;

   always_comb begin
      s4_valid_in = hsv.valid;
      s4_sat_in   = hsv.saturation;
      s4_val_in   = hsv.value;
      if (hsv.hue >= 13'd4800) begin
         s4_sector_in = hsvg_pkg::SEC_MR;
         frac_wide    = hsv.hue - 13'd4800;
      end else if (hsv.hue >= 13'd3840) begin
         s4_sector_in = hsvg_pkg::SEC_BM;
         frac_wide    = hsv.hue - 13'd3840;
      end else if (hsv.hue >= 13'd2880) begin
         s4_sector_in = hsvg_pkg::SEC_CB;
         frac_wide    = hsv.hue - 13'd2880;
      end else if (hsv.hue >= 13'd1920) begin
         s4_sector_in = hsvg_pkg::SEC_GC;
         frac_wide    = hsv.hue - 13'd1920;
      end else if (hsv.hue >= 13'd960) begin
         s4_sector_in = hsvg_pkg::SEC_YG;
         frac_wide    = hsv.hue - 13'd960;
      end else begin
         s4_sector_in = hsvg_pkg::SEC_RY;
         frac_wide    = hsv.hue;
      end
      s4_frac_in = frac_wide[hsvg_pkg::FRAC_W-1:0];
   end

   always_comb begin
      frac_rest    = hsvg_pkg::HUE_SECTOR - s4_frac_ff;
      sat_rest     = hsvg_pkg::UNIT_SV - s4_sat_ff;
      sf           = 19'(s4_sat_ff) * 19'(s4_frac_ff);
      st           = 19'(s4_sat_ff) * 19'(frac_rest);
      numq_wide    = hsvg_pkg::NUM_FULL - sf;
      numt_wide    = hsvg_pkg::NUM_FULL - st;
      s5_valid_in  = s4_valid_ff;
      s5_sector_in = s4_sector_ff;
      s5_grey_in   = (s4_sat_ff == '0);
      s5_val_in    = s4_val_ff;
      s5_numq_in   = numq_wide[hsvg_pkg::NUM_W-1:0];
      s5_numt_in   = numt_wide[hsvg_pkg::NUM_W-1:0];
      s5_pp_in     = 17'(s4_val_ff) * 17'(sat_rest);
   end

   always_comb begin
      v255         = 17'(s5_val_ff) * 17'd255;
      s6_valid_in  = s5_valid_ff;
      s6_sector_in = s5_sector_ff;
      s6_grey_in   = s5_grey_ff;
      s6_mq_in     = 27'(s5_val_ff) * 27'(s5_numq_ff);
      s6_mt_in     = 27'(s5_val_ff) * 27'(s5_numt_ff);
      s6_mp_in     = 25'(s5_pp_ff) * 25'd255;
      s6_vc_in     = v255[15:8];
   end

   always_comb begin
      q17 = {s6_mq_ff, 4'b0000} + 31'(s6_mq_ff);
      t17 = {s6_mt_ff, 4'b0000} + 31'(s6_mt_ff);
      qc  = q17[29:22];
      tc  = t17[29:22];
      pc  = s6_mp_ff[23:16];
      if (s6_grey_ff) begin
         red_in   = s6_vc_ff;
         green_in = s6_vc_ff;
         blue_in  = s6_vc_ff;
      end else begin
         case (s6_sector_ff)
            hsvg_pkg::SEC_RY: begin
               red_in = s6_vc_ff; green_in = tc; blue_in = pc;
            end
            hsvg_pkg::SEC_YG: begin
               red_in = qc; green_in = s6_vc_ff; blue_in = pc;
            end
            hsvg_pkg::SEC_GC: begin
               red_in = pc; green_in = s6_vc_ff; blue_in = tc;
            end
            hsvg_pkg::SEC_CB: begin
               red_in = pc; green_in = qc; blue_in = s6_vc_ff;
            end
            hsvg_pkg::SEC_BM: begin
               red_in = tc; green_in = pc; blue_in = s6_vc_ff;
            end
            default: begin
               red_in = s6_vc_ff; green_in = pc; blue_in = qc;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      s4_sector_ff <= s4_sector_in;
      s4_frac_ff   <= s4_frac_in;
      s4_sat_ff    <= s4_sat_in;
      s4_val_ff    <= s4_val_in;
      s5_sector_ff <= s5_sector_in;
      s5_grey_ff   <= s5_grey_in;
      s5_val_ff    <= s5_val_in;
      s5_numq_ff   <= s5_numq_in;
      s5_numt_ff   <= s5_numt_in;
      s5_pp_ff     <= s5_pp_in;
      s6_sector_ff <= s6_sector_in;
      s6_grey_ff   <= s6_grey_in;
      s6_mq_ff     <= s6_mq_in;
      s6_mt_ff     <= s6_mt_in;
      s6_mp_ff     <= s6_mp_in;
      s6_vc_ff     <= s6_vc_in;
      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
      if (reset) begin
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff  <= s4_valid_in;
         s5_valid_ff  <= s5_valid_in;
         s6_valid_ff  <= s6_valid_in;
         out_valid_ff <= s6_valid_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign red       = red_ff;
   assign green     = green_ff;
   assign blue      = blue_ff;

endmodule

// ----- hw/rtl/hsvg_checker.sv -----
// Port-level assertions for the HSV gradient to RGB core and their binding.
module hsvg_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic                              rsp_strobe,
   input  logic [hsvg_pkg::CH_W-1:0]         rsp_red,
   input  logic [hsvg_pkg::CH_W-1:0]         rsp_green,
   input  logic [hsvg_pkg::CH_W-1:0]         rsp_blue,
   input  logic                              csr_valid,
   input  logic                              csr_ready
);

   logic touched_ff;
   logic touched_in;

   assign touched_in = touched_ff || (csr_valid && csr_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         touched_ff <= 1'b0;
      end else begin
         touched_ff <= touched_in;
      end
   end

   // Every result comes from a transaction accepted earlier at the pipeline's input.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 7))
      else $error("result without a matching transaction");

   // A transaction that no reset interrupts always produces its result.
   a_no_lost: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) ##1 !reset ##1 !reset ##1 !reset ##1 !reset ##1 !reset
      ##1 !reset |=> rsp_strobe)
      else $error("transaction lost in the pipeline");

   // With the reset endpoints, value is zero and every color is black.
   a_reset_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !touched_ff) |->
      (rsp_red == '0 && rsp_green == '0 && rsp_blue == '0))
      else $error("nonzero color with reset endpoints");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write refused");

endmodule

bind hsv_gradient_to_rgb_core hsvg_checker u_checker (.*);
